### sv/gbr_pkg.sv
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared types, register offsets and helpers of the GPIO bank register block.
// ----------------------------------------------------------------------------
package gbr_pkg;

    // function-select layout
    localparam int FSEL_WORDS      = 6;
    localparam int FIELDS_PER_WORD = 10;
    localparam int FIELD_W         = 3;
    localparam int FSEL_W          = FIELDS_PER_WORD * FIELD_W;
    localparam int FSEL_IDX_W      = $clog2(FSEL_WORDS);

    // widths of the fixed access fields
    localparam int OFFSET_W = 6;
    localparam int DATA_W   = 32;
    localparam int LEVELS_W = 54;

    // register word offsets
    localparam logic [OFFSET_W-1:0] OFF_FSEL_FIRST = 6'd0;
    localparam logic [OFFSET_W-1:0] OFF_FSEL_LAST  = 6'd5;
    localparam logic [OFFSET_W-1:0] OFF_SET0       = 6'd7;
    localparam logic [OFFSET_W-1:0] OFF_SET1       = 6'd8;
    localparam logic [OFFSET_W-1:0] OFF_CLR0       = 6'd10;
    localparam logic [OFFSET_W-1:0] OFF_CLR1       = 6'd11;
    localparam logic [OFFSET_W-1:0] OFF_LEV0       = 6'd13;
    localparam logic [OFFSET_W-1:0] OFF_LEV1       = 6'd14;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register kind selected by an access
    typedef enum logic [2:0] {
        KIND_FSEL,
        KIND_SET,
        KIND_CLR,
        KIND_LEV,
        KIND_NONE
    } t_reg_kind;

    // decoded access, from the decoder to the register file
    typedef struct packed {
        logic                  wr;
        t_reg_kind             kind;
        logic                  bank;
        logic [FSEL_IDX_W-1:0] fsel_word;
    } t_access;

    // writable bits of one function-select word for a given pin count
    function automatic logic [FSEL_W-1:0] fsel_mask(input int pin_count, input int word);
        logic [FSEL_W-1:0] m;
        m = '0;
        for (int i = 0; i < FIELDS_PER_WORD; i++) begin
            if (word * FIELDS_PER_WORD + i < pin_count) begin
                m[i*FIELD_W +: FIELD_W] = '1;
            end
        end
        return m;
    endfunction

endpackage

### sv/gbr_decode.sv
// ----------------------------------------------------------------------------
// gbr_decode
// Register address decoder: turns an access into a register kind and bank.
// ----------------------------------------------------------------------------
module gbr_decode
    import gbr_pkg::*;
(
    input  logic                i_wr,
    input  logic [OFFSET_W-1:0] i_offset,
    output t_access             o_acc
);

    // offset decode, level words are read-only
    always_comb begin
        o_acc.wr        = i_wr;
        o_acc.kind      = KIND_NONE;
        o_acc.bank      = 1'b0;
        o_acc.fsel_word = i_offset[FSEL_IDX_W-1:0];
        unique case (i_offset) inside
            [OFF_FSEL_FIRST:OFF_FSEL_LAST]: begin
                o_acc.kind = KIND_FSEL;
            end
            OFF_SET0, OFF_SET1: begin
                o_acc.kind = KIND_SET;
                o_acc.bank = (i_offset == OFF_SET1);
            end
            OFF_CLR0, OFF_CLR1: begin
                o_acc.kind = KIND_CLR;
                o_acc.bank = (i_offset == OFF_CLR1);
            end
            OFF_LEV0, OFF_LEV1: begin
                o_acc.kind = i_wr ? KIND_NONE : KIND_LEV;
                o_acc.bank = (i_offset == OFF_LEV1);
            end
            default: begin
                o_acc.kind = KIND_NONE;
            end
        endcase
    end

endmodule

### sv/gbr_regfile.sv
// ----------------------------------------------------------------------------
// gbr_regfile
// Function-select and pin level storage with its read and update logic.
// ----------------------------------------------------------------------------
module gbr_regfile
    import gbr_pkg::*;
#(
    parameter int PIN_COUNT = 54
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_update,
    input  t_access             i_acc,
    input  logic [DATA_W-1:0]   i_wdata,
    output logic [DATA_W-1:0]   o_rdata,
    output logic                o_unimp,
    output logic [LEVELS_W-1:0] o_levels
);

    logic [FSEL_W-1:0]    r_fsel [FSEL_WORDS];
    logic [FSEL_W-1:0]    w_fsel_mask [FSEL_WORDS];
    logic [PIN_COUNT-1:0] r_level;
    logic [PIN_COUNT-1:0] n_level;
    logic [63:0]          w_cur64;
    logic [63:0]          w_new64;
    logic [63:0]          w_chg64;
    logic [DATA_W-1:0]    w_bank_lv;

    // writable field masks, fixed by the pin count
    for (genvar w = 0; w < FSEL_WORDS; w++) begin : g_mask
        assign w_fsel_mask[w] = fsel_mask(PIN_COUNT, w);
    end

    // level views
    assign w_cur64   = 64'(r_level);
    assign w_bank_lv = i_acc.bank ? w_cur64[63:32] : w_cur64[31:0];
    assign w_chg64   = i_acc.bank ? {i_wdata, 32'd0} : {32'd0, i_wdata};

    // read data and next levels
    always_comb begin
        o_rdata = '0;
        n_level = r_level;
        o_unimp = 1'b0;
        unique case (i_acc.kind)
            KIND_FSEL: begin
                if (!i_acc.wr) begin
                    o_rdata = DATA_W'(r_fsel[i_acc.fsel_word]);
                end
            end
            KIND_SET: begin
                if (i_acc.wr) begin
                    n_level = r_level | w_chg64[PIN_COUNT-1:0];
                end else begin
                    o_rdata = w_bank_lv;
                end
            end
            KIND_CLR: begin
                if (i_acc.wr) begin
                    n_level = r_level & ~w_chg64[PIN_COUNT-1:0];
                end else begin
                    o_rdata = ~w_bank_lv;
                end
            end
            KIND_LEV: begin
                o_rdata = w_bank_lv;
            end
            default: begin
                o_unimp = 1'b1;
            end
        endcase
    end

    assign w_new64  = 64'(n_level);
    assign o_levels = w_new64[LEVELS_W-1:0];

    // function-select words, unused fields stay zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < FSEL_WORDS; w++) begin
                r_fsel[w] <= '0;
            end
        end else if (i_update && i_acc.wr && i_acc.kind == KIND_FSEL) begin
            r_fsel[i_acc.fsel_word] <= i_wdata[FSEL_W-1:0] & w_fsel_mask[i_acc.fsel_word];
        end
    end

    // pin levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_update) begin
            r_level <= n_level;
        end
    end

endmodule

### sv/gpio_bank_registers.sv
// ----------------------------------------------------------------------------
// gpio_bank_registers
// GPIO bank register block: function select, set, clear and level words.
// ----------------------------------------------------------------------------
// Every access is one transfer in and one result transfer out. The block
// takes one access per cycle while the output is not stalled. A taken
// access is captured in the input register and its result in the result
// register, from which it transfers. The path is an input register, then a
// result register, and the register file reads and updates in the single pass between them.
// While a result waits, one more access can be held in the input register.
// Each result carries the read data (zero on writes), an unimplemented flag
// for offsets that name no register (including writes to the level words)
// and the level of every pin after the access.
module gpio_bank_registers
    import gbr_pkg::*;
#(
    parameter int PIN_COUNT = 54
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // word_offset[5:0], write_data[37:6]
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // read_data[31:0], pin_levels[85:32]
    output logic        m_axis_tuser   // unimplemented
);

    logic                r_in_valid;
    logic                r_in_wr;
    logic [OFFSET_W-1:0] r_in_offset;
    logic [DATA_W-1:0]   r_in_wdata;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_rdata;
    logic                r_out_unimp;
    logic [LEVELS_W-1:0] r_out_levels;
    logic                w_advance;
    logic                w_in_xfer;
    t_access             w_acc;
    logic [DATA_W-1:0]   w_rdata;
    logic                w_unimp;
    logic [LEVELS_W-1:0] w_levels;

    // pipeline flow control
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_wr     <= s_axis_tuser;
            r_in_offset <= s_axis_tdata[5:0];
            r_in_wdata  <= s_axis_tdata[37:6];
        end
    end

    gbr_decode u_decode (
        .i_wr     (r_in_wr),
        .i_offset (r_in_offset),
        .o_acc    (w_acc)
    );

    gbr_regfile #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (r_in_valid && w_advance),
        .i_acc    (w_acc),
        .i_wdata  (r_in_wdata),
        .o_rdata  (w_rdata),
        .o_unimp  (w_unimp),
        .o_levels (w_levels)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out_rdata  <= w_rdata;
            r_out_unimp  <= w_unimp;
            r_out_levels <= w_levels;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_unimp;
    assign m_axis_tdata  = {2'b00, r_out_levels, r_out_rdata};

endmodule

### sv/gbr_checker.sv
// ----------------------------------------------------------------------------
// gbr_checker
// Port-level checks of the GPIO bank register block.
// ----------------------------------------------------------------------------
module gbr_checker
    import gbr_pkg::*;
#(
    parameter int PIN_COUNT = 54
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // level bits of pins that do not exist
    localparam logic [LEVELS_W-1:0] GhostPins = (PIN_COUNT >= LEVELS_W) ? '0 :
        ~((LEVELS_W'(1) << PIN_COUNT) - LEVELS_W'(1));

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // unimplemented accesses return no data
    a_unimp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
        else $error("unimplemented access returned data");

    // missing pins never show a high level
    a_ghost_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[85:32] & GhostPins) == '0)
        else $error("level reported for a missing pin");

    // an empty pipeline always takes the next access
    a_take_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && $past(!s_axis_tvalid) && $past(i_rst_n) |-> s_axis_tready)
        else $error("access refused with an empty pipeline");

endmodule

bind gpio_bank_registers gbr_checker #(
    .PIN_COUNT (PIN_COUNT)
) u_gbr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### test/gpio_bank_registers_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_bank_registers_tb
// Self-checking bench for the GPIO bank register block.
// ----------------------------------------------------------------------------
// Register accesses are queued by the stimulus process and sent by a clocked
// driver. A clocked monitor mirrors the function-select fields and pin levels
// at every input transfer, queues the reply it should see, and compares each
// output transfer with the oldest queued reply. Phases vary sender idling and
// receiver stalling, and the sender drains fully between phases.
module gpio_bank_registers_tb;
    import gbr_pkg::*;

    localparam int PIN_COUNT = 54;

    // one register access as sent on the input stream
    typedef struct packed {
        logic                op;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   data;
    } t_bus_access;

    // one reply as carried on the output stream
    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic                unimplemented;
        logic [LEVELS_W-1:0] levels;
    } t_bus_reply;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // word_offset[5:0], write_data[37:6]
    logic        s_axis_tuser  = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;         // read_data[31:0], pin_levels[85:32]
    logic        m_axis_tuser;         // unimplemented

    t_bus_access access_q [$];
    t_bus_reply  reply_q [$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatches     = 0;

    // mirrored block state
    logic [FIELD_W-1:0]  fn_state [PIN_COUNT];
    logic [LEVELS_W-1:0] lvl_state;

    gpio_bank_registers #(
        .PIN_COUNT(PIN_COUNT)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // levels of one 32-pin bank, missing pins read zero
    function automatic logic [DATA_W-1:0] bank_word(input logic bank);
        logic [63:0] wide;
        wide = {{(64 - LEVELS_W){1'b0}}, lvl_state};
        return bank ? wide[63:32] : wide[31:0];
    endfunction

    // pins touched by a set or clear write to one bank
    function automatic logic [LEVELS_W-1:0] bank_mask(input logic bank,
                                                      input logic [DATA_W-1:0] data);
        logic [63:0] m;
        m = bank ? {data, 32'h0} : {32'h0, data};
        return m[LEVELS_W-1:0];
    endfunction

    // apply one access to the mirrored state and build its reply
    task automatic gpio_register_access(input t_bus_access a, output t_bus_reply r);
        logic              wr;
        logic [DATA_W-1:0] rd;
        int                pin;
        wr = (a.op == OP_WRITE);
        rd = '0;
        r  = '0;
        if (a.offset <= OFF_FSEL_LAST) begin
            for (int i = 0; i < FIELDS_PER_WORD; i++) begin
                pin = int'(a.offset) * FIELDS_PER_WORD + i;
                if (pin < PIN_COUNT) begin
                    if (wr) begin
                        fn_state[pin] = a.data[i*FIELD_W +: FIELD_W];
                    end else begin
                        rd[i*FIELD_W +: FIELD_W] = fn_state[pin];
                    end
                end
            end
        end else if (a.offset == OFF_SET0 || a.offset == OFF_SET1) begin
            if (wr) begin
                lvl_state = lvl_state | bank_mask(a.offset == OFF_SET1, a.data);
            end else begin
                rd = bank_word(a.offset == OFF_SET1);
            end
        end else if (a.offset == OFF_CLR0 || a.offset == OFF_CLR1) begin
            if (wr) begin
                lvl_state = lvl_state & ~bank_mask(a.offset == OFF_CLR1, a.data);
            end else begin
                rd = ~bank_word(a.offset == OFF_CLR1);
            end
        end else if (!wr && (a.offset == OFF_LEV0 || a.offset == OFF_LEV1)) begin
            rd = bank_word(a.offset == OFF_LEV1);
        end else begin
            // unknown offsets and writes to level words
            r.unimplemented = 1'b1;
        end
        r.read_data = wr ? '0 : rd;
        r.levels    = lvl_state;
    endtask

    // driver: present the next queued access once the current one is taken
    always @(posedge i_clk) begin : drive_proc
        t_bus_access nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = access_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, nxt.data, nxt.offset};
                s_axis_tuser  <= nxt.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: check output transfers, then mirror accepted accesses
    always @(posedge i_clk) begin : monitor_proc
        t_bus_access acc;
        t_bus_reply  want;
        if (!i_rst_n) begin
            for (int p = 0; p < PIN_COUNT; p++) begin
                fn_state[p] = '0;
            end
            lvl_state = '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (reply_q.size() == 0) begin
                    $error("unexpected output transfer: read_data %h", m_axis_tdata[31:0]);
                    mismatches++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.read_data) begin
                        $error("read_data: expected %h, actual %h",
                               want.read_data, m_axis_tdata[31:0]);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.unimplemented) begin
                        $error("unimplemented: expected %b, actual %b",
                               want.unimplemented, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[85:32] !== want.levels) begin
                        $error("pin_levels: expected %h, actual %h",
                               want.levels, m_axis_tdata[85:32]);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                acc.op     = s_axis_tuser;
                acc.offset = s_axis_tdata[5:0];
                acc.data   = s_axis_tdata[37:6];
                gpio_register_access(acc, want);
                reply_q = {reply_q, want};
            end
        end
    end

    task automatic push_access(input logic op, input logic [OFFSET_W-1:0] offset,
                               input logic [DATA_W-1:0] data);
        t_bus_access a;
        a.op     = op;
        a.offset = offset;
        a.data   = data;
        access_q = {access_q, a};
    endtask

    // random access, mostly to implemented registers
    task automatic push_random_access();
        logic [OFFSET_W-1:0] off;
        logic [DATA_W-1:0]   data;
        if ($urandom_range(9) < 8) begin
            case ($urandom_range(6))
                0:       off = OFF_SET0;
                1:       off = OFF_SET1;
                2:       off = OFF_CLR0;
                3:       off = OFF_CLR1;
                4:       off = OFF_LEV0;
                5:       off = OFF_LEV1;
                default: off = OFF_FSEL_FIRST + OFFSET_W'($urandom_range(FSEL_WORDS - 1));
            endcase
        end else begin
            off = OFFSET_W'($urandom_range(63));
        end
        case ($urandom_range(4))
            0:       data = $urandom & $urandom;
            1:       data = $urandom | $urandom;
            2:       data = 32'h1 << $urandom_range(31);
            3:       data = $urandom_range(1) ? '1 : '0;
            default: data = $urandom;
        endcase
        push_access($urandom_range(1) ? OP_WRITE : OP_READ, off, data);
    endtask

    // wait on the falling edge until the sender is empty and all replies seen
    task automatic wait_drained();
        @(negedge i_clk);
        while (access_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // reset, then phases of stimulus with different idling
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            @(negedge i_clk);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (ph == 0) begin
                // all fields of the first word, then the partly missing last word
                push_access(OP_READ,  OFF_FSEL_FIRST, '0);
                push_access(OP_WRITE, OFF_FSEL_FIRST, '1);
                push_access(OP_READ,  OFF_FSEL_FIRST, '0);
                push_access(OP_WRITE, OFF_FSEL_LAST,  '1);
                push_access(OP_READ,  OFF_FSEL_LAST,  '0);
                // raise every pin, including missing ones in bank 1
                push_access(OP_WRITE, OFF_SET0, '1);
                push_access(OP_WRITE, OFF_SET1, '1);
                push_access(OP_READ,  OFF_SET0, '0);
                push_access(OP_READ,  OFF_SET1, '0);
                push_access(OP_READ,  OFF_CLR0, '0);
                push_access(OP_READ,  OFF_CLR1, '0);
                // clear alternating pins
                push_access(OP_WRITE, OFF_CLR0, 32'hAAAA_AAAA);
                push_access(OP_WRITE, OFF_CLR1, 32'h5555_5555);
                push_access(OP_READ,  OFF_LEV0, '0);
                push_access(OP_READ,  OFF_LEV1, '0);
                // level words are read-only
                push_access(OP_WRITE, OFF_LEV0, '1);
                push_access(OP_WRITE, OFF_LEV1, '1);
                // gaps in the map and the top offset
                push_access(OP_READ,  OFF_FSEL_LAST + 1'b1, '0);
                push_access(OP_READ,  OFF_SET1 + 1'b1, '0);
                push_access(OP_READ,  OFF_CLR1 + 1'b1, '0);
                push_access(OP_READ,  OFF_LEV1 + 1'b1, '0);
                push_access(OP_WRITE, '1, '1);
                push_access(OP_READ,  '1, '0);
                push_access(OP_WRITE, OFF_FSEL_FIRST, '0);
                push_access(OP_READ,  OFF_FSEL_FIRST, '0);
            end
            for (int n = 0; n < 106; n++) begin
                push_random_access();
            end
            // sender holds off until the phase has fully drained
            wait_drained();
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
